FILE: hdl/assert_macros.svh
// Assertion macros used by the touch-key event mapper RTL.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TKEM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TKEM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TKEM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define TKEM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/tkem_pkg.sv
// Types, widths and register codes of the touch-key event mapper.
// No dependencies; the RTL modules and the testbench use it by scoped names.
package tkem_pkg;

   localparam int MAP_ENTRIES_DEF = 4;
   localparam int KEY_BITS_DEF    = 10;
   localparam int REG_ENTRIES     = 4;
   localparam int MASK_W          = 10;
   localparam int CODE_W          = 10;
   localparam int SAMPLE_W        = 16;
   localparam int ENTRY_W         = 20;
   localparam int PAIR_W          = 40;
   localparam int COUNT_W         = 3;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = PAIR_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE     = 2'd0,
      CSR_MAP_COUNT  = 2'd1,
      CSR_MAP_PAIR_0 = 2'd2,
      CSR_MAP_PAIR_1 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] key_bits;
      logic                read_ok;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] key_id;
      logic              pressed;
      logic              last_event;
   } rsp_type;

   // Layout matches one 20-bit half of a map pair register.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [MASK_W-1:0] mask;
   } entry_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              pressed;
   } evt_type;

   typedef struct packed {
      logic    push;
      logic    finish;
      evt_type evt;
   } evt_ctl_type;

   typedef struct packed {
      logic push_ready;
      logic finish_ready;
      logic pend_valid;
   } evt_stat_type;

endpackage

FILE: hdl/touch_key_event_mapper.sv
// Touch-key event mapper: polled key bitmaps in, press/release events out.
// Depends on tkem_pkg, tkem_seq, tkem_event_buf and assert_macros.svh.
//
// Usage:
//  - req channel (valid/ready) carries one sample: key_bits and read_ok.
//  - rsp channel (valid/ready) carries one event per beat: key_id, pressed,
//    and last_event on the final event of a sample. A sample may cause none.
//  - csr port writes enable, map_count and the two map pair registers; write
//    only while the block is idle.
//  - A disabled block or a sample with read_ok low is taken whenever the
//    block is idle and leaves no trace.
//  - Otherwise one compare unit walks the map one entry per cycle while the
//    event buffer takes its events: a release pass over the map entries
//    (when masks differ or no key is set), then a press pass over each key
//    bit and map entry, then a final step that flushes the last event, after
//    which req_ready rises again.
//  - An event is held until the next event of its sample is found or the walk
//    ends, since only then is it known to be the last; it then waits in the
//    output register until its beat is taken.
//  - With both event registers full, low rsp_ready holds the walk's next push.
//  - Synchronous reset clears the masks, the registers and all valid state.
`include "assert_macros.svh"
module touch_key_event_mapper #(
   parameter int MAP_ENTRIES = tkem_pkg::MAP_ENTRIES_DEF,
   parameter int KEY_BITS    = tkem_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tkem_pkg::req_type                 req,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tkem_pkg::rsp_type                 rsp,
   input  logic                              csr_write_en,
   input  logic [tkem_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tkem_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic                                             enable_ff;
   logic [tkem_pkg::COUNT_W-1:0]                     map_count_ff;
   logic [tkem_pkg::PAIR_W-1:0]                      pair0_ff;
   logic [tkem_pkg::PAIR_W-1:0]                      pair1_ff;
   tkem_pkg::entry_type [tkem_pkg::REG_ENTRIES-1:0] entries;
   logic                                             seq_idle;
   logic                                             start;
   tkem_pkg::evt_ctl_type                            evt_ctl;
   tkem_pkg::evt_stat_type                           evt_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         map_count_ff <= '0;
         pair0_ff     <= '0;
         pair1_ff     <= '0;
      end else if (csr_write_en) begin
         unique case (tkem_pkg::csr_index_type'(csr_index))
            tkem_pkg::CSR_ENABLE:     enable_ff    <= csr_data[0];
            tkem_pkg::CSR_MAP_COUNT:  map_count_ff <= csr_data[tkem_pkg::COUNT_W-1:0];
            tkem_pkg::CSR_MAP_PAIR_0: pair0_ff     <= csr_data[tkem_pkg::PAIR_W-1:0];
            tkem_pkg::CSR_MAP_PAIR_1: pair1_ff     <= csr_data[tkem_pkg::PAIR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      entries[0] = tkem_pkg::entry_type'(pair0_ff[tkem_pkg::ENTRY_W-1:0]);
      entries[1] = tkem_pkg::entry_type'(pair0_ff[tkem_pkg::PAIR_W-1:tkem_pkg::ENTRY_W]);
      entries[2] = tkem_pkg::entry_type'(pair1_ff[tkem_pkg::ENTRY_W-1:0]);
      entries[3] = tkem_pkg::entry_type'(pair1_ff[tkem_pkg::PAIR_W-1:tkem_pkg::ENTRY_W]);
   end

   assign req_ready = seq_idle;
   // drop samples from a failed read or while disabled
   assign start     = req_valid && req_ready && enable_ff && req.read_ok;

   tkem_seq #(
      .MAP_ENTRIES(MAP_ENTRIES),
      .KEY_BITS   (KEY_BITS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sample (req.key_bits),
      .entries(entries),
      .count  (map_count_ff),
      .idle   (seq_idle),
      .ctl    (evt_ctl),
      .stat   (evt_stat)
   );

   tkem_event_buf u_event_buf (
      .clock    (clock),
      .reset    (reset),
      .ctl      (evt_ctl),
      .stat     (evt_stat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp)
   );

   `TKEM_ASSERT_IMPL(a_accept_clean, clock, reset, req_valid && req_ready, !evt_stat.pend_valid && !evt_ctl.push, "sample accepted with an event still held")
   `TKEM_ASSERT_NEXT(a_push_holds, clock, reset, evt_ctl.push && !evt_stat.push_ready, evt_ctl.push, "stalled event was dropped by the sequencer")
   `TKEM_ASSERT_NEXT(a_last_marked, clock, reset, evt_ctl.finish && evt_stat.finish_ready && evt_stat.pend_valid, rsp_valid && rsp.last_event, "final event of a sample not marked last")

endmodule

FILE: hdl/tkem_match.sv
// Shared compare unit: selects one map entry and tests its mask against an operand.
// Depends on tkem_pkg.
module tkem_match #(
   parameter int MAP_ENTRIES = tkem_pkg::MAP_ENTRIES_DEF,
   localparam int IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1
) (
   input  tkem_pkg::entry_type [tkem_pkg::REG_ENTRIES-1:0] entries,
   input  logic [tkem_pkg::COUNT_W-1:0]                     count,
   input  logic [IDX_W-1:0]                                 idx,
   input  logic [tkem_pkg::MASK_W-1:0]                      operand,
   output logic                                             hit,
   output logic [tkem_pkg::CODE_W-1:0]                      code
);

   localparam logic [tkem_pkg::COUNT_W-1:0] MAX_CNT = tkem_pkg::COUNT_W'(MAP_ENTRIES);

   tkem_pkg::entry_type               sel;
   logic [tkem_pkg::COUNT_W-1:0]      count_eff;
   logic                              in_use;

   always_comb begin
      sel = '0;
      // entries without a register keep an empty mask
      for (int e = 0; e < tkem_pkg::REG_ENTRIES; e++) begin
         if (tkem_pkg::COUNT_W'(idx) == tkem_pkg::COUNT_W'(e)) begin
            sel = entries[e];
         end
      end
      count_eff = (count > MAX_CNT) ? MAX_CNT : count;
      in_use    = tkem_pkg::COUNT_W'(idx) < count_eff;
      hit       = in_use && (|(sel.mask & operand));
      code      = sel.code;
   end

endmodule

FILE: hdl/tkem_event_buf.sv
// Event buffer: holds the newest event until the next one (or the end of the
// sample) shows whether it is the last, then moves it to the output register.
// Depends on tkem_pkg.
module tkem_event_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  tkem_pkg::evt_ctl_type  ctl,
   output tkem_pkg::evt_stat_type stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tkem_pkg::rsp_type      rsp
);

   logic              pend_valid_ff, pend_valid_in;
   tkem_pkg::evt_type pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   tkem_pkg::rsp_type out_ff, out_in;
   logic              out_free;
   logic              move;
   logic              push_take;
   logic              fin_take;

   always_comb begin
      out_free          = !out_valid_ff || rsp_ready;
      stat.push_ready   = !pend_valid_ff || out_free;
      stat.finish_ready = !pend_valid_ff || out_free;
      stat.pend_valid   = pend_valid_ff;
      push_take         = ctl.push && stat.push_ready;
      fin_take          = ctl.finish && stat.finish_ready;
      move              = pend_valid_ff && out_free && (ctl.push || ctl.finish);

      out_valid_in = move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_in       = out_ff;
      if (move) begin
         out_in.key_id     = pend_ff.code;
         out_in.pressed    = pend_ff.pressed;
         out_in.last_event = ctl.finish;
      end

      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (push_take) begin
         pend_valid_in = 1'b1;
         pend_in       = ctl.evt;
      end else if (fin_take) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

FILE: hdl/tkem_seq.sv
// Sequencer: walks the release pass over map entries if needed, then the press
// pass over key bits and map entries, one compare per cycle through tkem_match
// unless the event buffer holds a push. Depends on tkem_pkg and tkem_match.
module tkem_seq #(
   parameter int MAP_ENTRIES = tkem_pkg::MAP_ENTRIES_DEF,
   parameter int KEY_BITS    = tkem_pkg::KEY_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             start,
   input  logic [tkem_pkg::SAMPLE_W-1:0]                    sample,
   input  tkem_pkg::entry_type [tkem_pkg::REG_ENTRIES-1:0] entries,
   input  logic [tkem_pkg::COUNT_W-1:0]                     count,
   output logic                                             idle,
   output tkem_pkg::evt_ctl_type                            ctl,
   input  tkem_pkg::evt_stat_type                           stat
);

   localparam int IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int KB_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam logic [tkem_pkg::MASK_W-1:0] KEY_MASK =
      tkem_pkg::MASK_W'((1 << KEY_BITS) - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_REL  = 4'b0010,
      ST_PRS  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [IDX_W-1:0]              j_ff, j_in;
   logic [KB_W-1:0]               i_ff, i_in;
   logic [tkem_pkg::MASK_W-1:0]   sample_ff, sample_in;
   logic [tkem_pkg::MASK_W-1:0]   prev_ff, prev_in;
   logic [tkem_pkg::MASK_W-1:0]   active_ff, active_in;
   logic [tkem_pkg::MASK_W-1:0]   sample_m;
   logic [tkem_pkg::MASK_W-1:0]   bit_vec;
   logic [tkem_pkg::MASK_W-1:0]   operand;
   logic                          hit;
   logic [tkem_pkg::CODE_W-1:0]   code;
   logic                          need_push;
   logic                          advance;
   logic                          last_j;
   logic                          last_i;

   tkem_match #(
      .MAP_ENTRIES(MAP_ENTRIES)
   ) u_match (
      .entries(entries),
      .count  (count),
      .idx    (j_ff),
      .operand(operand),
      .hit    (hit),
      .code   (code)
   );

   always_comb begin
      sample_m = sample[tkem_pkg::MASK_W-1:0] & KEY_MASK;
      bit_vec  = tkem_pkg::MASK_W'(1) << i_ff;
      operand  = (state_ff == ST_REL) ? prev_ff : (bit_vec & sample_ff);
      last_j   = j_ff == IDX_W'(MAP_ENTRIES - 1);
      last_i   = i_ff == KB_W'(KEY_BITS - 1);

      need_push = 1'b0;
      if (state_ff == ST_REL) begin
         need_push = hit;
      end else if (state_ff == ST_PRS) begin
         need_push = hit && (prev_ff == '0);
      end
      // hold the step while the event buffer cannot take the beat
      advance = !need_push || stat.push_ready;

      ctl.push        = need_push;
      ctl.finish      = state_ff == ST_DONE;
      ctl.evt.code    = code;
      ctl.evt.pressed = state_ff == ST_PRS;
      idle            = state_ff == ST_IDLE;

      state_in  = state_ff;
      j_in      = j_ff;
      i_in      = i_ff;
      sample_in = sample_ff;
      prev_in   = prev_ff;
      active_in = active_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sample_in = sample_m;
               j_in      = '0;
               i_in      = '0;
               if ((prev_ff != active_ff) || (sample_m == '0)) begin
                  state_in = ST_REL;
               end else begin
                  prev_in  = active_ff;
                  state_in = ST_PRS;
               end
            end
         end
         ST_REL: begin
            if (advance) begin
               if (hit) begin
                  active_in = '0;
               end
               if (last_j) begin
                  j_in     = '0;
                  prev_in  = hit ? '0 : active_ff;
                  state_in = ST_PRS;
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end
         end
         ST_PRS: begin
            if (advance) begin
               if (hit) begin
                  active_in = active_ff | bit_vec;
               end
               if (last_j) begin
                  j_in = '0;
                  i_in = i_ff + KB_W'(1);
                  if (last_i) begin
                     state_in = ST_DONE;
                  end
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (stat.finish_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         prev_ff   <= '0;
         active_ff <= '0;
      end else begin
         state_ff  <= state_in;
         prev_ff   <= prev_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff      <= j_in;
      i_ff      <= i_in;
      sample_ff <= sample_in;
   end

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for touch_key_event_mapper: directed and random samples and map
// settings, with expected key events worked out alongside. Depends on tkem_pkg and the RTL only.
`timescale 1ns / 100ps
module tb_top;

   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 400000;

   logic                            clock        = 1'b0;
   logic                            reset        = 1'b1;
   logic                            req_valid    = 1'b0;
   logic                            req_ready;
   tkem_pkg::req_type               req          = '0;
   logic                            rsp_valid;
   logic                            rsp_ready    = 1'b0;
   tkem_pkg::rsp_type               rsp;
   logic                            csr_write_en = 1'b0;
   logic [tkem_pkg::CSR_IDX_W-1:0]  csr_index    = tkem_pkg::CSR_ENABLE;
   logic [tkem_pkg::CSR_DATA_W-1:0] csr_data     = '0;

   // register shadows and key state of the event predictor
   logic                            cfg_enable = 1'b0;
   logic [tkem_pkg::COUNT_W-1:0]    cfg_count  = '0;
   tkem_pkg::entry_type             map_entries [tkem_pkg::REG_ENTRIES];
   logic [tkem_pkg::MASK_W-1:0]     prev_keys  = '0;
   logic [tkem_pkg::MASK_W-1:0]     held_keys  = '0;

   tkem_pkg::req_type               sample_queue [$];
   tkem_pkg::rsp_type               expected_events [$];
   tkem_pkg::rsp_type               want_event;

   int                    req_gap_max   = 0;
   int                    req_gap_left  = 0;
   int                    rsp_stall_max = 0;
   int                    rsp_stall_left = 0;
   int                    hold_left     = 0;
   bit                    hold_arm      = 1'b0;
   bit                    hold_seen     = 1'b0;
   logic                  req_took      = 1'b0;
   logic                  rsp_took      = 1'b0;
   int                    error_count   = 0;
   int                    cycle_count   = 0;

   touch_key_event_mapper u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req          (req),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp          (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("%0t ERROR %s", $time, msg);
      error_count++;
   endtask

   // Release pass over the last active mask when needed, then a press pass per set key bit.
   function automatic void predict_key_events(input tkem_pkg::req_type s);
      logic [tkem_pkg::MASK_W-1:0] keys;
      int unsigned                 used;
      int                          n;
      n = 0;
      if (!cfg_enable || !s.read_ok)
         return;
      keys = s.key_bits[tkem_pkg::MASK_W-1:0];
      used = (cfg_count > tkem_pkg::MAP_ENTRIES_DEF) ? tkem_pkg::MAP_ENTRIES_DEF : cfg_count;
      if (prev_keys != held_keys || keys == '0) begin
         for (int j = 0; j < used; j++) begin
            if ((map_entries[j].mask & prev_keys) != '0) begin
               expected_events.push_back(
                  tkem_pkg::rsp_type'{map_entries[j].code, 1'b0, 1'b0});
               n++;
               held_keys = '0;
            end
         end
      end
      prev_keys = held_keys;
      for (int i = 0; i < tkem_pkg::KEY_BITS_DEF; i++) begin
         if (keys[i]) begin
            for (int j = 0; j < used; j++) begin
               if (map_entries[j].mask[i]) begin
                  if (prev_keys == '0) begin
                     expected_events.push_back(
                        tkem_pkg::rsp_type'{map_entries[j].code, 1'b1, 1'b0});
                     n++;
                  end
                  held_keys[i] = 1'b1;
               end
            end
         end
      end
      if (n > 0)
         expected_events[expected_events.size()-1].last_event = 1'b1;
   endfunction

   task automatic write_register(input tkem_pkg::csr_index_type idx,
                                 input logic [tkem_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         tkem_pkg::CSR_ENABLE:     cfg_enable = value[0];
         tkem_pkg::CSR_MAP_COUNT:  cfg_count  = value[tkem_pkg::COUNT_W-1:0];
         tkem_pkg::CSR_MAP_PAIR_0: begin
            map_entries[0] = value[tkem_pkg::ENTRY_W-1:0];
            map_entries[1] = value[tkem_pkg::PAIR_W-1:tkem_pkg::ENTRY_W];
         end
         tkem_pkg::CSR_MAP_PAIR_1: begin
            map_entries[2] = value[tkem_pkg::ENTRY_W-1:0];
            map_entries[3] = value[tkem_pkg::PAIR_W-1:tkem_pkg::ENTRY_W];
         end
      endcase
   endtask

   task automatic set_enable(input logic on);
      write_register(tkem_pkg::CSR_ENABLE, {$urandom, 7'($urandom), on});
   endtask

   task automatic set_map_count(input logic [tkem_pkg::COUNT_W-1:0] n);
      write_register(tkem_pkg::CSR_MAP_COUNT, {$urandom, 5'($urandom), n});
   endtask

   task automatic queue_sample(input logic [tkem_pkg::SAMPLE_W-1:0] bits, input logic ok);
      sample_queue.push_back(tkem_pkg::req_type'{bits, ok});
   endtask

   // Hold until the sender is drained and every event is back, then let the walk finish.
   task automatic wait_idle();
      @(posedge clock);
      while (sample_queue.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic tkem_pkg::entry_type random_entry();
      tkem_pkg::entry_type e;
      e.code = 10'($urandom);
      case ($urandom_range(0, 3))
         0: e.mask = 10'(1) << $urandom_range(0, 9);
         1: e.mask = 10'($urandom);
         2: e.mask = 10'h3FF;
         default: e.mask = (10'(1) << $urandom_range(0, 9)) | (10'(1) << $urandom_range(0, 9));
      endcase
      return e;
   endfunction

   task automatic randomize_map();
      set_enable($urandom_range(0, 7) != 0);
      set_map_count(($urandom_range(0, 9) < 7) ? 3'd4 : 3'($urandom_range(0, 7)));
      write_register(tkem_pkg::CSR_MAP_PAIR_0, {random_entry(), random_entry()});
      write_register(tkem_pkg::CSR_MAP_PAIR_1, {random_entry(), random_entry()});
   endtask

   // Mostly press / hold / release runs on mapped keys; the rest is noise.
   task automatic queue_random_samples(input int n);
      int                          left;
      int                          reps;
      logic [tkem_pkg::MASK_W-1:0] pat;
      left = n;
      while (left > 0) begin
         if ($urandom_range(0, 6) == 0) begin
            queue_sample(16'($urandom), $urandom_range(0, 3) != 0);
            left--;
         end else begin
            pat = map_entries[$urandom_range(0, 3)].mask & 10'($urandom);
            if (pat == '0)
               pat = 10'(1) << $urandom_range(0, 9);
            reps = $urandom_range(1, 3);
            repeat (reps) queue_sample({6'($urandom), pat}, $urandom_range(0, 15) != 0);
            left -= reps;
            // drop the release now and then so runs collide
            if ($urandom_range(0, 3) != 0) begin
               reps = $urandom_range(1, 2);
               repeat (reps) queue_sample({6'($urandom), 10'h000}, 1'b1);
               left -= reps;
            end
         end
      end
   endtask

   // sender: new beat at the falling edge, hold it until taken
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_took)) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req          <= sample_queue.pop_front();
            req_valid    <= 1'b1;
            req_gap_left = $urandom_range(0, req_gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: a random stall after each beat, or one long hold when armed
   always @(negedge clock) begin
      if (hold_arm != hold_seen) begin
         hold_seen = hold_arm;
         hold_left = HOLD_CYCLES;
      end
      if (rsp_took)
         rsp_stall_left = $urandom_range(0, rsp_stall_max);
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      req_took <= req_valid && req_ready;
      rsp_took <= rsp_valid && rsp_ready;
      if (!reset) begin
         if (req_valid && req_ready)
            predict_key_events(req);
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               report_error($sformatf("unexpected event code %h pressed %b last %b",
                                      rsp.key_id, rsp.pressed, rsp.last_event));
            end else begin
               want_event = expected_events.pop_front();
               if (rsp.key_id !== want_event.key_id)
                  report_error($sformatf("key_id %h, want %h",
                                         rsp.key_id, want_event.key_id));
               if (rsp.pressed !== want_event.pressed)
                  report_error($sformatf("pressed %b, want %b (code %h)",
                                         rsp.pressed, want_event.pressed, want_event.key_id));
               if (rsp.last_event !== want_event.last_event)
                  report_error($sformatf("last_event %b, want %b (code %h)",
                                         rsp.last_event, want_event.last_event,
                                         want_event.key_id));
            end
         end
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      foreach (map_entries[j])
         map_entries[j] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled out of reset: samples leave no trace
      queue_sample(16'h03FF, 1'b1);
      queue_sample(16'hFFFF, 1'b1);
      wait_idle();

      set_enable(1'b1);
      set_map_count(3'd4);
      write_register(tkem_pkg::CSR_MAP_PAIR_0,
                     {tkem_pkg::entry_type'{10'h3FF, 10'h200},
                      tkem_pkg::entry_type'{10'h000, 10'h3FF}});
      write_register(tkem_pkg::CSR_MAP_PAIR_1,
                     {tkem_pkg::entry_type'{10'h2AA, 10'h0F0},
                      tkem_pkg::entry_type'{10'h155, 10'h001}});
      rsp_stall_max = 4;
      req_gap_max   = 4;
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'hFC01, 1'b1);
      queue_sample(16'h0001, 1'b1);
      queue_sample(16'h0001, 1'b1);
      queue_sample(16'h0200, 1'b1);
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'h03FF, 1'b1);
      queue_sample(16'h03FF, 1'b0);
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'h0000, 1'b1);
      wait_idle();

      // every entry on every key: the longest press and release bursts
      write_register(tkem_pkg::CSR_MAP_PAIR_0,
                     {2{tkem_pkg::entry_type'{10'h3C3, 10'h3FF}}});
      write_register(tkem_pkg::CSR_MAP_PAIR_1,
                     {tkem_pkg::entry_type'{10'h001, 10'h3FF},
                      tkem_pkg::entry_type'{10'h3FE, 10'h3FF}});
      queue_sample(16'h03FF, 1'b1);
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'h0000, 1'b1);
      wait_idle();

      // count past the map size is clamped
      set_map_count(3'd7);
      queue_sample(16'h00F1, 1'b1);
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'h0000, 1'b1);
      wait_idle();
      set_map_count(3'd0);
      queue_sample(16'h03FF, 1'b1);
      queue_sample(16'h0000, 1'b1);
      wait_idle();
      set_enable(1'b0);
      queue_sample(16'h03FF, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         randomize_map();
         if (phase == 0) begin
            req_gap_max   = 0;
            rsp_stall_max = 0;
         end else if (phase == 2) begin
            // fill the block while the receiver is held off
            set_enable(1'b1);
            set_map_count(3'd4);
            req_gap_max   = 0;
            rsp_stall_max = 1;
            hold_arm      = !hold_arm;
         end else begin
            req_gap_max   = $urandom_range(0, 4);
            rsp_stall_max = $urandom_range(0, 4);
         end
         queue_random_samples(26);
         wait_idle();
      end

      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
